/* hw/rtl/ttl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttl_pkg
// Types and constants shared by the text token lexer modules.
// ----------------------------------------------------------------------------
package ttl_pkg;

	localparam int LINE_NO_W  = 24;
	localparam int FIFO_DEPTH = 4;

	typedef struct packed {
		logic [7:0] in_char;
		logic       is_end;
	} ttl_in_t;

	typedef struct packed {
		logic [2:0]           token_kind;
		logic [7:0]           text_byte;
		logic                 byte_valid;
		logic                 token_last;
		logic [1:0]           err_code;
		logic [LINE_NO_W-1:0] line_no;
	} ttl_out_t;

	typedef struct packed {
		logic not_empty;
		logic room_two;
	} ttl_fifo_stat_t;

	typedef enum logic [2:0] {
		MODE_SKIP,
		MODE_COMMENT,
		MODE_WORD,
		MODE_STRING,
		MODE_ESCAPE,
		MODE_QCHAR,
		MODE_QCLOSE
	} ttl_mode_t;

	localparam logic [2:0] KIND_EOF      = 3'd0;
	localparam logic [2:0] KIND_INT      = 3'd1;
	localparam logic [2:0] KIND_STR      = 3'd2;
	localparam logic [2:0] KIND_IDENT    = 3'd3;
	localparam logic [2:0] KIND_LABEL    = 3'd4;
	localparam logic [2:0] KIND_LABELREF = 3'd5;
	localparam logic [2:0] KIND_FLOAT    = 3'd6;
	localparam logic [2:0] KIND_PUNCT    = 3'd7;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_EOF_STR = 2'd1;
	localparam logic [1:0] ERR_NL_STR  = 2'd2;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	localparam logic [7:0] MAX_LEN_RESET = 8'd255;

endpackage
`default_nettype wire

/* hw/rtl/ttl_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttl_core
// Lexer state and per-byte mode update; yields up to two results per item.
// ----------------------------------------------------------------------------
module ttl_core #(
	parameter int LINE_BITS = 24
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire ttl_pkg::ttl_in_t item,
	input  wire logic [7:0]       max_len,
	output ttl_pkg::ttl_out_t     res [2],
	output logic [1:0]            res_n
);

	localparam int EXT_W = (LINE_BITS > ttl_pkg::LINE_NO_W) ? LINE_BITS : ttl_pkg::LINE_NO_W;

	ttl_pkg::ttl_mode_t   mode_q, mode_d;
	logic [2:0]           kind_q, kind_d;
	logic [7:0]           cnt_q, cnt_d;
	logic [LINE_BITS-1:0] line_q, line_d;
	logic [EXT_W-1:0]     line_ext;
	logic [ttl_pkg::LINE_NO_W-1:0] line_no;

	logic [7:0] c;
	logic       eoi;
	logic       sp;
	logic       fresh;
	logic       wk_ok;
	logic [2:0] wk;

	function automatic ttl_pkg::ttl_out_t mk(input logic [2:0] k, input logic [7:0] b,
			input logic v, input logic l, input logic [1:0] e,
			input logic [ttl_pkg::LINE_NO_W-1:0] ln);
		ttl_pkg::ttl_out_t r;
		r.token_kind = k;
		r.text_byte  = b;
		r.byte_valid = v;
		r.token_last = l;
		r.err_code   = e;
		r.line_no    = ln;
		return r;
	endfunction

	assign c   = item.in_char;
	assign eoi = item.is_end;
	assign sp  = (c == ttl_pkg::CH_TAB) || (c == ttl_pkg::CH_NL) ||
	             (c == ttl_pkg::CH_CR) || (c == ttl_pkg::CH_SPACE);

	// count the newline before anything is emitted
	assign line_d   = (!eoi && c == ttl_pkg::CH_NL && !(&line_q)) ? line_q + 1'b1 : line_q;
	assign line_ext = EXT_W'(line_d);
	assign line_no  = line_ext[ttl_pkg::LINE_NO_W-1:0];

	always_comb begin
		wk_ok = 1'b1;
		wk    = ttl_pkg::KIND_PUNCT;
		if (c == ttl_pkg::CH_DOLLAR) begin
			wk = ttl_pkg::KIND_LABELREF;
		end else if (c == ttl_pkg::CH_COLON) begin
			wk = ttl_pkg::KIND_LABEL;
		end else if (c == ttl_pkg::CH_DOT) begin
			wk = ttl_pkg::KIND_FLOAT;
		end else if (c == ttl_pkg::CH_MINUS || c inside {[8'h30:8'h39]}) begin
			wk = ttl_pkg::KIND_INT;
		end else if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]} || c == ttl_pkg::CH_UNDER) begin
			wk = ttl_pkg::KIND_IDENT;
		end else begin
			wk_ok = 1'b0;
		end
	end

	always_comb begin
		res[0] = '0;
		res[1] = '0;
		res_n  = 2'd0;
		mode_d = mode_q;
		kind_d = kind_q;
		cnt_d  = cnt_q;
		fresh  = 1'b0;
		case (mode_q)
			ttl_pkg::MODE_WORD: begin
				if (eoi || sp || c == ttl_pkg::CH_SEMI) begin
					res[0] = mk(kind_q, 8'd0, 1'b0, 1'b1, ttl_pkg::ERR_NONE, line_no);
					res_n  = 2'd1;
					mode_d = ttl_pkg::MODE_SKIP;
					fresh  = 1'b1;
				end else if (cnt_q < max_len) begin
					res[0] = mk(kind_q, c, 1'b1, 1'b0, ttl_pkg::ERR_NONE, line_no);
					res_n  = 2'd1;
					cnt_d  = cnt_q + 8'd1;
				end
			end
			ttl_pkg::MODE_STRING, ttl_pkg::MODE_ESCAPE: begin
				if (eoi) begin
					res[0] = mk(ttl_pkg::KIND_STR, 8'd0, 1'b0, 1'b1, ttl_pkg::ERR_EOF_STR,
					            line_no);
					res[1] = mk(ttl_pkg::KIND_EOF, 8'd0, 1'b0, 1'b1, ttl_pkg::ERR_NONE, line_no);
					res_n  = 2'd2;
					mode_d = ttl_pkg::MODE_SKIP;
				end else if (mode_q == ttl_pkg::MODE_ESCAPE ||
				             !(c == ttl_pkg::CH_DQUOTE || c == ttl_pkg::CH_NL ||
				               c == ttl_pkg::CH_BSLASH)) begin
					// escaped or ordinary byte: keep it while under the limit
					if (cnt_q < max_len) begin
						res[0] = mk(ttl_pkg::KIND_STR, c, 1'b1, 1'b0, ttl_pkg::ERR_NONE, line_no);
						res_n  = 2'd1;
						cnt_d  = cnt_q + 8'd1;
					end
					mode_d = ttl_pkg::MODE_STRING;
				end else if (c == ttl_pkg::CH_DQUOTE) begin
					res[0] = mk(ttl_pkg::KIND_STR, 8'd0, 1'b0, 1'b1, ttl_pkg::ERR_NONE, line_no);
					res_n  = 2'd1;
					mode_d = ttl_pkg::MODE_SKIP;
				end else if (c == ttl_pkg::CH_NL) begin
					res[0] = mk(ttl_pkg::KIND_STR, 8'd0, 1'b0, 1'b1, ttl_pkg::ERR_NL_STR,
					            line_no);
					res_n  = 2'd1;
					mode_d = ttl_pkg::MODE_SKIP;
				end else begin
					mode_d = ttl_pkg::MODE_ESCAPE;
				end
			end
			ttl_pkg::MODE_QCHAR: begin
				if (eoi) begin
					res[0] = mk(ttl_pkg::KIND_EOF, 8'd0, 1'b0, 1'b1, ttl_pkg::ERR_NONE, line_no);
					mode_d = ttl_pkg::MODE_SKIP;
				end else begin
					res[0] = mk(ttl_pkg::KIND_INT, c, 1'b1, 1'b1, ttl_pkg::ERR_NONE, line_no);
					mode_d = ttl_pkg::MODE_QCLOSE;
				end
				res_n = 2'd1;
			end
			ttl_pkg::MODE_QCLOSE: begin
				// consume the closing byte whatever it is
				if (eoi) begin
					res[0] = mk(ttl_pkg::KIND_EOF, 8'd0, 1'b0, 1'b1, ttl_pkg::ERR_NONE, line_no);
					res_n  = 2'd1;
				end
				mode_d = ttl_pkg::MODE_SKIP;
			end
			ttl_pkg::MODE_COMMENT: begin
				if (eoi) begin
					res[0] = mk(ttl_pkg::KIND_EOF, 8'd0, 1'b0, 1'b1, ttl_pkg::ERR_NONE, line_no);
					res_n  = 2'd1;
					mode_d = ttl_pkg::MODE_SKIP;
				end else if (c == ttl_pkg::CH_NL) begin
					mode_d = ttl_pkg::MODE_SKIP;
				end
			end
			default: begin
				mode_d = ttl_pkg::MODE_SKIP;
				fresh  = 1'b1;
			end
		endcase

		// start of a token; a word close may already sit in slot 0
		if (fresh) begin
			if (eoi) begin
				res[res_n[0]] = mk(ttl_pkg::KIND_EOF, 8'd0, 1'b0, 1'b1, ttl_pkg::ERR_NONE,
				                   line_no);
				res_n = res_n + 2'd1;
			end else if (sp) begin
				mode_d = ttl_pkg::MODE_SKIP;
			end else if (c == ttl_pkg::CH_SEMI) begin
				mode_d = ttl_pkg::MODE_COMMENT;
			end else if (c == ttl_pkg::CH_SQUOTE) begin
				mode_d = ttl_pkg::MODE_QCHAR;
			end else if (c == ttl_pkg::CH_DQUOTE) begin
				cnt_d  = 8'd0;
				mode_d = ttl_pkg::MODE_STRING;
			end else if (wk_ok) begin
				kind_d = wk;
				mode_d = ttl_pkg::MODE_WORD;
				if (max_len != 8'd0) begin
					res[res_n[0]] = mk(wk, c, 1'b1, 1'b0, ttl_pkg::ERR_NONE, line_no);
					res_n = res_n + 2'd1;
					cnt_d = 8'd1;
				end else begin
					cnt_d = 8'd0;
				end
			end else begin
				res[res_n[0]] = mk(ttl_pkg::KIND_PUNCT, c, 1'b1, 1'b1, ttl_pkg::ERR_NONE,
				                   line_no);
				res_n = res_n + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ttl_pkg::MODE_SKIP;
			kind_q <= 3'd0;
			cnt_q  <= 8'd0;
			line_q <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			kind_q <= kind_d;
			cnt_q  <= cnt_d;
			line_q <= line_d;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/ttl_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttl_fifo
// Result queue: takes zero, one or two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module ttl_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [1:0]        push_n,
	input  wire ttl_pkg::ttl_out_t push_data [2],
	input  wire logic              pop,
	output ttl_pkg::ttl_out_t      head,
	output ttl_pkg::ttl_fifo_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ttl_pkg::ttl_out_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q, wr_nx;
	logic [CNT_W-1:0]  count_q;

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_nx = nxt(wr_q);
	assign head  = mem_q[rd_q];

	assign stat.not_empty = (count_q != '0);
	assign stat.room_two  = (count_q <= CNT_W'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= push_data[0];
		end
		if (push_n == 2'd2) begin
			mem_q[wr_nx] <= push_data[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			case (push_n)
				2'd1:    wr_q <= wr_nx;
				2'd2:    wr_q <= nxt(wr_nx);
				default: wr_q <= wr_q;
			endcase
			if (pop) begin
				rd_q <= nxt(rd_q);
			end
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/text_token_lexer_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_token_lexer_top
// Streaming tokenizer: one text byte or end mark in, token bytes out.
// ----------------------------------------------------------------------------
// One byte enters per cycle into an item register unless that register holds.
// The lexer then updates its mode and writes up to two results into a four-entry
// result queue. The first result of an item passes from the item register through
// the lexer into the result queue, whose head is the output. The output side moves
// one result per cycle while tok_stall is low. Bytes that give at most one result
// flow at one per cycle while the output is not stalled. Only the end mark that
// closes a word or cuts a string gives two results. The item register holds when
// the queue has fewer than two free entries. The user must write max_text_len
// through cfg only while the block is idle; the block does not enforce this.
module text_token_lexer_top #(
	parameter int LINE_BITS = 24
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              char_valid,
	output logic                   char_stall,
	input  wire ttl_pkg::ttl_in_t  char_data,
	output logic                   tok_valid,
	input  wire logic              tok_stall,
	output ttl_pkg::ttl_out_t      tok_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [7:0]        cfg_data
);

	logic              valid_s1;
	ttl_pkg::ttl_in_t  item_s1;
	logic              fire_s1;
	logic              take;
	logic [7:0]        max_len_q;
	ttl_pkg::ttl_out_t res [2];
	logic [1:0]        res_n;
	logic [1:0]        push_n;
	ttl_pkg::ttl_fifo_stat_t stat;

	assign cfg_ready  = 1'b1;
	assign fire_s1    = valid_s1 && stat.room_two;
	assign char_stall = valid_s1 && !stat.room_two;
	assign take       = char_valid && !char_stall;
	assign push_n     = fire_s1 ? res_n : 2'd0;
	assign tok_valid  = stat.not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= ttl_pkg::MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= char_data;
		end
	end

	ttl_core #(
		.LINE_BITS(LINE_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire_s1),
		.item    (item_s1),
		.max_len (max_len_q),
		.res     (res),
		.res_n   (res_n)
	);

	ttl_fifo #(
		.DEPTH(ttl_pkg::FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_data (res),
		.pop       (tok_valid && !tok_stall),
		.head      (tok_data),
		.stat      (stat)
	);

	// an accepted byte is held in the item register on the next cycle
	a_item_held: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_s1)
		else $error("accepted byte lost from item register");

	// results without a text byte always close a token
	a_close_last: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && !tok_data.byte_valid) |-> tok_data.token_last)
		else $error("empty result does not close token");

	// errors are reported only on a string close
	a_err_str: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && tok_data.err_code != ttl_pkg::ERR_NONE) |->
		(tok_data.token_kind == ttl_pkg::KIND_STR && tok_data.token_last))
		else $error("error code outside string close");

	// the queue is never asked to take more than it has room for
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> stat.room_two)
		else $error("result queue overflow");

endmodule
`default_nettype wire
